// File: hdl/assert_macros.svh
// Assertion macros for the warp grid sampler RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define WGBS_ASSERT_NOW(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication.
`define WGBS_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

// File: hdl/wgbs_pkg.sv
// Shared types and constants of the warp grid bilinear sampler.
// No dependencies.
package wgbs_pkg;

    localparam int GRID_N_DEF  = 32;
    localparam int MID_DEPTH   = 4;
    localparam int OUT_DEPTH   = 16;
    localparam int PIPE_STAGES = 7;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_MARGIN = 2'd1;
    localparam logic [1:0] CFG_ISPAN  = 2'd2;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic signed [19:0] MIN20 = -20'sd524288;
    localparam logic signed [19:0] MAX20 = 20'sd524287;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        K_WRITE,
        K_GRID,
        K_PASS
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [1:0]         ch;
        logic [4:0]         col;
        logic [4:0]         row;
        logic signed [19:0] a;
        logic signed [19:0] b;
    } t_item;

    typedef struct packed {
        logic        enable;
        logic [15:0] margin;
        logic [16:0] ispan;
    } t_cfg;

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
    } t_result;

endpackage

// File: hdl/wgbs_fifo.sv
// Small first-in first-out queue of registers.
// Standalone; used between front and back and on the result side.
module wgbs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [W-1:0]                 i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic [W-1:0]                 o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH+1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [NW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
        end
        n_cnt = r_cnt + NW'(do_push) - NW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: hdl/wgbs_front.sv
// Front end: classifies incoming words into node writes, grid samples and pass-through.
// Depends on wgbs_pkg.
module wgbs_front #(
    parameter int GRID_N = wgbs_pkg::GRID_N_DEF
) (
    input  logic                i_enable,
    input  logic                i_opcode,
    input  logic [1:0]          i_channel,
    input  logic [4:0]          i_node_col,
    input  logic [4:0]          i_node_row,
    input  logic signed [19:0]  i_node_u,
    input  logic signed [19:0]  i_node_v,
    input  logic signed [19:0]  i_query_x,
    input  logic signed [19:0]  i_query_y,
    output logic                o_keep,
    output wgbs_pkg::t_item     o_item
);
    import wgbs_pkg::*;

    logic [7:0] col8, row8;
    logic       ch_ok;

    assign col8  = {3'b000, i_node_col};
    assign row8  = {3'b000, i_node_row};
    assign ch_ok = (i_channel != 2'd3);

    always_comb begin
        o_item.ch  = i_channel;
        o_item.col = i_node_col;
        o_item.row = i_node_row;
        if (i_opcode == OP_WRITE) begin
            o_item.kind = K_WRITE;
            o_item.a    = i_node_u;
            o_item.b    = i_node_v;
            o_keep      = ch_ok && (col8 < 8'(GRID_N)) && (row8 < 8'(GRID_N));
        end else begin
            o_item.kind = (i_enable && ch_ok) ? K_GRID : K_PASS;
            o_item.a    = i_query_x;
            o_item.b    = i_query_y;
            o_keep      = 1'b1;
        end
    end

endmodule

// File: hdl/wgbs_back.sv
// Back end: coordinate mapping, four-bank grid memory and bilinear interpolation pipeline.
// Depends on wgbs_pkg.
module wgbs_back #(
    parameter int GRID_N = wgbs_pkg::GRID_N_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  wgbs_pkg::t_cfg          i_cfg,
    input  wgbs_pkg::t_item         i_item,
    input  logic                    i_item_empty,
    output logic                    o_item_pop,
    input  logic [$clog2(wgbs_pkg::OUT_DEPTH+1)-1:0] i_out_count,
    output logic                    o_res_valid,
    output wgbs_pkg::t_result       o_res
);
    import wgbs_pkg::*;

    localparam int CW     = $clog2(GRID_N);
    localparam int FW     = 17 + CW;
    localparam int HALF   = (GRID_N + 1) / 2;
    localparam int BDEPTH = 3 * HALF * HALF;
    localparam int AW     = $clog2(BDEPTH);

    logic [PIPE_STAGES-1:0] r_vld;
    t_item r_it0, r_it1, r_it2, r_it3, r_it4, r_it5, r_it6;

    // Issue only when the result queue has room for everything in flight.
    assign o_item_pop = !i_item_empty &&
        ((32'(i_out_count) + 32'($countones(r_vld))) < 32'(OUT_DEPTH));

    // Offset and scale.
    logic signed [20:0] qm_x, qm_y;
    logic signed [38:0] n_px, n_py, r_px, r_py;
    assign qm_x = 21'(r_it0.a) + $signed({5'b0, i_cfg.margin});
    assign qm_y = 21'(r_it0.b) + $signed({5'b0, i_cfg.margin});
    assign n_px = qm_x * $signed({1'b0, i_cfg.ispan});
    assign n_py = qm_y * $signed({1'b0, i_cfg.ispan});

    function automatic logic [16:0] unit_clamp(input logic signed [38:0] p);
        logic signed [22:0] sh;
        sh = p[38:16];
        if (p <= 0) begin
            return '0;
        end else if (sh > 23'sd65536) begin
            return ONE_Q16;
        end else begin
            return sh[16:0];
        end
    endfunction

    // Scale to grid units.
    logic [FW-1:0] n_fx, n_fy, r_fx, r_fy;
    assign n_fx = FW'(unit_clamp(r_px)) * FW'(GRID_N - 1);
    assign n_fy = FW'(unit_clamp(r_py)) * FW'(GRID_N - 1);

    // Cell index, fraction and bank addresses.
    logic [CW:0]   ix_raw, jy_raw;
    logic [CW-1:0] ix, jy;
    logic [FW-1:0] tfx, tfy;
    logic [16:0]   n_tx, n_ty;
    logic [CW-1:0] row_e, row_o, col_e, col_o;
    logic [AW-1:0] ch_base;
    logic [AW-1:0] raddr [4];

    assign ix_raw = r_fx[FW-1:16];
    assign jy_raw = r_fy[FW-1:16];
    assign ix = (ix_raw > (CW+1)'(GRID_N - 2)) ? CW'(GRID_N - 2) : ix_raw[CW-1:0];
    assign jy = (jy_raw > (CW+1)'(GRID_N - 2)) ? CW'(GRID_N - 2) : jy_raw[CW-1:0];
    assign tfx  = r_fx - (FW'(ix) << 16);
    assign tfy  = r_fy - (FW'(jy) << 16);
    assign n_tx = tfx[16:0];
    assign n_ty = tfy[16:0];
    assign col_e = (ix >> 1) + CW'(ix[0]);
    assign col_o = ix >> 1;
    assign row_e = (jy >> 1) + CW'(jy[0]);
    assign row_o = jy >> 1;
    assign ch_base = AW'(r_it2.ch) * AW'(HALF * HALF);

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            raddr[b] = ch_base
                + AW'(b[1] ? row_o : row_e) * AW'(HALF)
                + AW'(b[0] ? col_o : col_e);
        end
    end

    // Node write address.
    logic          wen;
    logic [1:0]    wbank;
    logic [AW-1:0] waddr;
    assign wen   = r_vld[2] && (r_it2.kind == K_WRITE);
    assign wbank = {r_it2.row[0], r_it2.col[0]};
    assign waddr = ch_base + AW'(r_it2.row >> 1) * AW'(HALF) + AW'(r_it2.col >> 1);

    logic [39:0] r_mem [4][BDEPTH];
    logic [39:0] r_rd  [4];

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 4; b++) begin
            if (wen && (wbank == 2'(b))) begin
                r_mem[b][waddr] <= {r_it2.a, r_it2.b};
            end
            r_rd[b] <= r_mem[b][raddr[b]];
        end
    end

    logic [16:0] r_tx3, r_ty3, r_ty4, r_ty5;
    logic        r_ip3, r_jp3;

    // Horizontal weights.
    logic [39:0] c00, c10, c01, c11;
    logic [17:0] wx0, wx1;
    logic signed [37:0] n_pu [4];
    logic signed [37:0] n_pv [4];
    logic signed [37:0] r_pu [4];
    logic signed [37:0] r_pv [4];

    assign c00 = r_rd[{r_jp3, r_ip3}];
    assign c10 = r_rd[{r_jp3, ~r_ip3}];
    assign c01 = r_rd[{~r_jp3, r_ip3}];
    assign c11 = r_rd[{~r_jp3, ~r_ip3}];
    assign wx0 = {1'b0, ONE_Q16 - r_tx3};
    assign wx1 = {1'b0, r_tx3};

    always_comb begin
        n_pu[0] = $signed(c00[39:20]) * $signed(wx0);
        n_pu[1] = $signed(c10[39:20]) * $signed(wx1);
        n_pu[2] = $signed(c01[39:20]) * $signed(wx0);
        n_pu[3] = $signed(c11[39:20]) * $signed(wx1);
        n_pv[0] = $signed(c00[19:0]) * $signed(wx0);
        n_pv[1] = $signed(c10[19:0]) * $signed(wx1);
        n_pv[2] = $signed(c01[19:0]) * $signed(wx0);
        n_pv[3] = $signed(c11[19:0]) * $signed(wx1);
    end

    logic signed [37:0] r_au, r_bu, r_av, r_bv;

    // Vertical weights.
    logic [17:0] wy0, wy1;
    logic signed [55:0] r_ru0, r_ru1, r_rv0, r_rv1;
    assign wy0 = {1'b0, ONE_Q16 - r_ty5};
    assign wy1 = {1'b0, r_ty5};

    function automatic logic signed [19:0] round_sat(input logic signed [55:0] r);
        logic signed [23:0] sh;
        sh = r[55:32];
        if (sh < 24'(MIN20)) begin
            return MIN20;
        end else if (sh > 24'(MAX20)) begin
            return MAX20;
        end else begin
            return sh[19:0];
        end
    endfunction

    logic signed [55:0] sum_u, sum_v;
    assign sum_u = r_ru0 + r_ru1 + 56'sh80000000;
    assign sum_v = r_rv0 + r_rv1 + 56'sh80000000;

    assign o_res_valid = r_vld[6] && (r_it6.kind != K_WRITE);
    always_comb begin
        if (r_it6.kind == K_GRID) begin
            o_res.x = round_sat(sum_u);
            o_res.y = round_sat(sum_v);
        end else begin
            o_res.x = r_it6.a;
            o_res.y = r_it6.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_STAGES-2:0], o_item_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        r_it0 <= i_item;
        r_it1 <= r_it0;
        r_px  <= n_px;
        r_py  <= n_py;
        r_it2 <= r_it1;
        r_fx  <= n_fx;
        r_fy  <= n_fy;
        r_it3 <= r_it2;
        r_tx3 <= n_tx;
        r_ty3 <= n_ty;
        r_ip3 <= ix[0];
        r_jp3 <= jy[0];
        r_it4 <= r_it3;
        r_ty4 <= r_ty3;
        for (int k = 0; k < 4; k++) begin
            r_pu[k] <= n_pu[k];
            r_pv[k] <= n_pv[k];
        end
        r_it5 <= r_it4;
        r_ty5 <= r_ty4;
        r_au  <= r_pu[0] + r_pu[1];
        r_bu  <= r_pu[2] + r_pu[3];
        r_av  <= r_pv[0] + r_pv[1];
        r_bv  <= r_pv[2] + r_pv[3];
        r_it6 <= r_it5;
        r_ru0 <= r_au * $signed(wy0);
        r_ru1 <= r_bu * $signed(wy1);
        r_rv0 <= r_av * $signed(wy0);
        r_rv1 <= r_bv * $signed(wy1);
    end

endmodule

// File: hdl/warp_grid_bilinear_sampler_unit.sv
// Warp grid bilinear sampler takes one word per clock while full is low and returns
// one result word per sample. Grid memory is split into four banks by row and column
// parity so that all four corners of a cell are read in the same cycle. Issue into the
// pipeline is held back by a credit check against the 16-word result queue, so a
// stalled consumer fills that queue and then the 4-word input queue before full rises.
// Grid contents are undefined until written; no clearing pass is done.
`include "assert_macros.svh"

module warp_grid_bilinear_sampler_unit #(
    parameter int GRID_N = wgbs_pkg::GRID_N_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_opcode,
    input  logic [1:0]         i_channel,
    input  logic [4:0]         i_node_col,
    input  logic [4:0]         i_node_row,
    input  logic signed [19:0] i_node_u,
    input  logic signed [19:0] i_node_v,
    input  logic signed [19:0] i_query_x,
    input  logic signed [19:0] i_query_y,
    output logic               empty,
    input  logic               pop,
    output logic signed [19:0] o_warped_x,
    output logic signed [19:0] o_warped_y,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);
    import wgbs_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable <= 1'b0;
            r_cfg.margin <= '0;
            r_cfg.ispan  <= ONE_Q16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE: r_cfg.enable <= i_cfg_data[0];
                CFG_MARGIN: r_cfg.margin <= i_cfg_data[15:0];
                CFG_ISPAN:  r_cfg.ispan  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic  w_keep;
    t_item w_front_item, w_mid_item;
    logic  w_mid_full, w_mid_empty, w_mid_pop;
    logic [$clog2(MID_DEPTH+1)-1:0] w_mid_count;

    wgbs_front #(.GRID_N(GRID_N)) u_front (
        .i_enable   (r_cfg.enable),
        .i_opcode   (i_opcode),
        .i_channel  (i_channel),
        .i_node_col (i_node_col),
        .i_node_row (i_node_row),
        .i_node_u   (i_node_u),
        .i_node_v   (i_node_v),
        .i_query_x  (i_query_x),
        .i_query_y  (i_query_y),
        .o_keep     (w_keep),
        .o_item     (w_front_item)
    );

    assign full = w_mid_full;

    wgbs_fifo #(.W($bits(t_item)), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && w_keep),
        .i_data  (w_front_item),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_item),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    logic    w_res_valid, w_out_full;
    t_result w_res, w_out_data;
    logic [$clog2(OUT_DEPTH+1)-1:0] w_out_count;

    wgbs_back #(.GRID_N(GRID_N)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item       (w_mid_item),
        .i_item_empty (w_mid_empty),
        .o_item_pop   (w_mid_pop),
        .i_out_count  (w_out_count),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    wgbs_fifo #(.W($bits(t_result)), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out_data),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    assign o_warped_x = w_out_data.x;
    assign o_warped_y = w_out_data.y;

    `WGBS_ASSERT_NOW(a_no_result_overflow, w_res_valid, !w_out_full)
    `WGBS_ASSERT_NOW(a_mid_pop_nonempty, w_mid_pop, !w_mid_empty)
    `WGBS_ASSERT_NEXT(a_result_shows, w_res_valid, !empty)
    `WGBS_ASSERT_NOW(a_mid_count_bound, w_mid_full, w_mid_count != '0)

endmodule

// File: verif/tb.sv
// Testbench for the warp grid bilinear sampler: directed and random node writes and
// samples, checked against a bit-true predictor kept in this file.
// Depends on wgbs_pkg and warp_grid_bilinear_sampler_unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wgbs_pkg::*;

    localparam int N = 32;
    localparam int LIMIT = 2000000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic push = 0;
    logic full;
    logic i_opcode = 0;
    logic [1:0] i_channel = 0;
    logic [4:0] i_node_col = 0;
    logic [4:0] i_node_row = 0;
    logic signed [19:0] i_node_u = 0;
    logic signed [19:0] i_node_v = 0;
    logic signed [19:0] i_query_x = 0;
    logic signed [19:0] i_query_y = 0;
    logic empty;
    logic pop = 0;
    logic signed [19:0] o_warped_x;
    logic signed [19:0] o_warped_y;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = 0;
    logic [16:0] i_cfg_data = 0;

    warp_grid_bilinear_sampler_unit u_top (.*);

    t_cfg cfg_shadow;
    logic signed [19:0] node_u_mem [3*N*N];
    logic signed [19:0] node_v_mem [3*N*N];
    t_result warp_expected [$];
    int errors = 0;
    int cycles = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int hold_pop = 0;

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic longint unit_coord(logic signed [19:0] q);
        longint p;
        longint s;
        p = (longint'(q) + longint'(cfg_shadow.margin)) * longint'(cfg_shadow.ispan);
        if (p <= 0) return 0;
        s = p >>> 16;
        return (s > 65536) ? 65536 : s;
    endfunction

    function automatic logic signed [19:0] blend(longint c00, longint c10, longint c01,
                                                 longint c11, longint tx, longint ty);
        longint a;
        longint b;
        longint r;
        a = c00 * (65536 - tx) + c10 * tx;
        b = c01 * (65536 - tx) + c11 * tx;
        r = (a * (65536 - ty) + b * ty + (longint'(1) << 31)) >>> 32;
        if (r < -524288) r = -524288;
        if (r > 524287) r = 524287;
        return r[19:0];
    endfunction

    function automatic int node_idx(int ch, int row, int col);
        return ch * N * N + row * N + col;
    endfunction

    function automatic void predict_warp(logic op, logic [1:0] ch, logic [4:0] col,
            logic [4:0] row, logic signed [19:0] u, logic signed [19:0] v,
            logic signed [19:0] qx, logic signed [19:0] qy);
        longint fx;
        longint fy;
        longint i0;
        longint j0;
        int k;
        t_result r;
        if (op == OP_WRITE) begin
            if (ch < 3) begin
                k = node_idx(int'(ch), int'(row), int'(col));
                node_u_mem[k] = u;
                node_v_mem[k] = v;
            end
            return;
        end
        if (!cfg_shadow.enable || ch == 3) begin
            r.x = qx;
            r.y = qy;
        end else begin
            fx = unit_coord(qx) * (N - 1);
            fy = unit_coord(qy) * (N - 1);
            i0 = fx >>> 16;
            j0 = fy >>> 16;
            if (i0 > N - 2) i0 = N - 2;
            if (j0 > N - 2) j0 = N - 2;
            k = node_idx(int'(ch), int'(j0), int'(i0));
            r.x = blend(node_u_mem[k], node_u_mem[k+1], node_u_mem[k+N], node_u_mem[k+N+1],
                        fx - i0 * 65536, fy - j0 * 65536);
            r.y = blend(node_v_mem[k], node_v_mem[k+1], node_v_mem[k+N], node_v_mem[k+N+1],
                        fx - i0 * 65536, fy - j0 * 65536);
        end
        warp_expected.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        if (hold_pop > 0) begin
            hold_pop <= hold_pop - 1;
            pop <= 0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall);
        end
        if (i_rst_n && pop && !empty) begin
            if (warp_expected.size() == 0) begin
                $display("%t unexpected word x=%0d y=%0d", $realtime, o_warped_x, o_warped_y);
                errors++;
            end else begin
                t_result e;
                e = warp_expected.pop_front();
                if (e.x !== o_warped_x || e.y !== o_warped_y) begin
                    $display("%t mismatch expected x=%0d y=%0d actual x=%0d y=%0d",
                             $realtime, e.x, e.y, o_warped_x, o_warped_y);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(logic op, logic [1:0] ch, logic [4:0] col, logic [4:0] row,
            logic signed [19:0] u, logic signed [19:0] v,
            logic signed [19:0] qx, logic signed [19:0] qy);
        while ($urandom_range(99) < send_idle) begin
            push <= 0;
            @(posedge i_clk);
        end
        push <= 1;
        i_opcode <= op;
        i_channel <= ch;
        i_node_col <= col;
        i_node_row <= row;
        i_node_u <= u;
        i_node_v <= v;
        i_query_x <= qx;
        i_query_y <= qy;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_warp(op, ch, col, row, u, v, qx, qy);
    endtask

    task automatic drain();
        push <= 0;
        while (warp_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        drain();
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        case (idx)
            CFG_ENABLE: cfg_shadow.enable = val[0];
            CFG_MARGIN: cfg_shadow.margin = val[15:0];
            default: cfg_shadow.ispan = val;
        endcase
    endtask

    task automatic apply_cfg(logic en, logic [15:0] m, logic [16:0] s);
        write_reg(CFG_ENABLE, 17'(en));
        write_reg(CFG_MARGIN, 17'(m));
        write_reg(CFG_ISPAN, s);
    endtask

    function automatic logic signed [19:0] rand20();
        case ($urandom_range(5))
            0: return MIN20;
            1: return MAX20;
            2: return 20'($urandom_range(65536));
            3: return 20'($urandom_range(70000)) - 20'sd2000;
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic fill_grids();
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < N; r++)
                for (int k = 0; k < N; k++)
                    send_item(OP_WRITE, 2'(c), 5'(k), 5'(r), rand20(), rand20(), rand20(),
                              rand20());
    endtask

    task automatic sample(logic [1:0] ch);
        send_item(OP_SAMPLE, ch, 5'($urandom), 5'($urandom), 20'($urandom), 20'($urandom),
                  rand20(), rand20());
    endtask

    task automatic test_pass_through();
        sample(0);
        send_item(OP_SAMPLE, 3, 31, 31, MAX20, MIN20, MIN20, MAX20);
        send_item(OP_SAMPLE, 1, 0, 0, 0, 0, MAX20, MIN20);
        send_item(OP_SAMPLE, 2, 0, 0, 0, 0, 0, 20'sd65536);
    endtask

    task automatic test_directed();
        apply_cfg(1, 0, 65536);
        send_item(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_SAMPLE, 1, 0, 0, 0, 0, 20'sd65536, 20'sd65536);
        send_item(OP_SAMPLE, 2, 0, 0, 0, 0, MIN20, MAX20);
        send_item(OP_SAMPLE, 0, 0, 0, 0, 0, 20'sd32768, 20'sd2114);
        send_item(OP_SAMPLE, 3, 0, 0, 0, 0, 20'sd1234, -20'sd99);
        send_item(OP_WRITE, 3, 0, 0, MAX20, MAX20, 0, 0);
        send_item(OP_WRITE, 0, 0, 0, MAX20, MIN20, 0, 0);
        send_item(OP_WRITE, 0, 1, 0, MAX20, MIN20, 0, 0);
        send_item(OP_WRITE, 0, 0, 1, MAX20, MIN20, 0, 0);
        send_item(OP_WRITE, 0, 1, 1, MAX20, MIN20, 0, 0);
        send_item(OP_SAMPLE, 0, 0, 0, 0, 0, 20'sd1000, 20'sd1000);
        apply_cfg(1, 32768, 32768);
        send_item(OP_SAMPLE, 0, 0, 0, 0, 0, -20'sd32768, 20'sd65536 + 20'sd32768);
        apply_cfg(1, 16'hffff, 17'h1ffff);
        send_item(OP_SAMPLE, 1, 0, 0, 0, 0, 20'sd100, MIN20);
        apply_cfg(1, 0, 0);
        send_item(OP_SAMPLE, 2, 0, 0, 0, 0, MAX20, 20'sd7);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0)
                send_item(OP_WRITE, 2'($urandom_range(3)), 5'($urandom), 5'($urandom),
                          rand20(), rand20(), 20'($urandom), 20'($urandom));
            else
                sample(2'($urandom_range(3)));
        end
    endtask

    task automatic test_backpressure();
        hold_pop = 300;
        for (int n = 0; n < 60; n++) sample(2'($urandom_range(2)));
        drain();
        for (int n = 0; n < 20; n++) sample(2'($urandom_range(2)));
    endtask

    task automatic test_phases();
        logic [15:0] m;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 50; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 50; end
                default: begin send_idle = 26; recv_stall = 26; end
            endcase
            m = 16'($urandom_range(32768));
            apply_cfg($urandom_range(5) != 0, m,
                      17'(((longint'(1) << 32) / (65536 + 2 * longint'(m)))));
            test_random(220);
        end
        send_idle = 0;
        recv_stall = 0;
    endtask

    initial begin
        cfg_shadow = '{enable: 0, margin: 0, ispan: 17'h10000};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_pass_through();
        fill_grids();
        test_directed();
        test_backpressure();
        test_phases();
        drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: warp_grid_bilinear_sampler_unit.f
+incdir+hdl
hdl/wgbs_pkg.sv
hdl/wgbs_fifo.sv
hdl/wgbs_front.sv
hdl/wgbs_back.sv
hdl/warp_grid_bilinear_sampler_unit.sv
verif/tb.sv
